### hdl/assert_macros.svh
// Assertion helper macros used by the band-to-column converter back end.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RBHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define RBHC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/rbhc_pkg.sv
// Shared types and constants for the band-to-column converter.
// No dependencies; used by every module of the block.
package rbhc_pkg;

  localparam int BandRowsDefault = 48;
  localparam int MaxBandRows     = 64;

  localparam int ByteW   = 8;
  localparam int MarginW = 8;
  localparam int ColsW   = 10;
  localparam int RowsW   = 12;
  localparam int SkipW   = 10;
  localparam int CountW  = 13;
  localparam int FeedW   = $clog2(MaxBandRows + 1);
  localparam int DoneW   = RowsW + 1;

  localparam int CmdQDepth = 2;

  localparam int RegIdxW = 2;
  localparam int AddrW   = RegIdxW + 2;
  localparam int DataW   = 32;

  typedef enum logic [RegIdxW-1:0] {
    RegLeftMargin,
    RegStartOffset,
    RegColumnBytes,
    RegTotalRows
  } reg_idx_t;

  typedef struct packed {
    logic [MarginW-1:0] left_margin;
    logic [MarginW-1:0] start_offset;
    logic [ColsW-1:0]   column_bytes;
    logic [RowsW-1:0]   total_rows;
  } cfg_t;

  // One unit of work for the back end: band prefix, data group and feed.
  typedef struct packed {
    logic              has_prefix;
    logic              has_cr;
    logic [SkipW-1:0]  skip;
    logic [CountW-1:0] gwidth;
    logic              has_data;
    logic              has_feed;
    logic [FeedW-1:0]  feed;
  } cmd_t;

endpackage

### hdl/rbhc_cmdq.sv
// Short command queue between the front and back ends.
// Depends on rbhc_pkg for the command type and depth.
module rbhc_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rbhc_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output rbhc_pkg::cmd_t dout
);

  localparam int Depth = rbhc_pkg::CmdQDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  rbhc_pkg::cmd_t        entry_r [Depth];
  logic [PtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign valid   = (cnt_r != '0);
  assign dout    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

### hdl/rbhc_front.sv
// Front end: accepts row bytes, tracks row/column/band position, builds
// commands and collects each column group. Depends on rbhc_pkg.
module rbhc_front #(
  parameter int BAND_ROWS = rbhc_pkg::BandRowsDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rbhc_pkg::cfg_t                         cfg,
  input  logic                                   push,
  output logic                                   full,
  input  logic [rbhc_pkg::ByteW-1:0]             in_pixel_byte,
  output logic                                   cmd_push,
  output rbhc_pkg::cmd_t                         cmd,
  input  logic                                   cmdq_full,
  input  logic                                   bank_busy,
  output logic                                   bank_load,
  output logic [BAND_ROWS/8*8-1:0][rbhc_pkg::ByteW-1:0] bank_data
);

  localparam int Blocks = BAND_ROWS / 8;
  localparam int NB     = Blocks * 8;
  localparam int RowW   = $clog2(BAND_ROWS);
  localparam int ColsW  = rbhc_pkg::ColsW;
  localparam int DoneW  = rbhc_pkg::DoneW;
  localparam int FeedW  = rbhc_pkg::FeedW;
  localparam int SkipW  = rbhc_pkg::SkipW;

  logic [RowW-1:0]                      row_r, row_nxt;
  logic [ColsW-1:0]                     col_r, col_nxt;
  logic [DoneW-1:0]                     done_r, done_nxt;
  logic                                 open_r, open_nxt;
  logic [NB-1:0][rbhc_pkg::ByteW-1:0]   line_r, line_nxt, line_sh;

  logic [ColsW-1:0]  cols;
  logic [ColsW:0]    col_inc;
  logic [DoneW-1:0]  total_x, diff;
  logic [FeedW-1:0]  rem, feed;
  logic              last_row, needs_cmd, accept, store, band_end, page_end;

  always_comb begin
    cols      = (cfg.column_bytes == '0) ? ColsW'(1) : cfg.column_bytes;
    last_row  = (row_r == RowW'(BAND_ROWS - 1));
    needs_cmd = !open_r || last_row;
    full      = (needs_cmd && cmdq_full) || (last_row && bank_busy);
    accept    = push && !full;
    // rows beyond the last full block are dropped
    store     = ({1'b0, row_r} < (RowW + 1)'(NB));

    for (int i = 0; i < NB - 1; i++) begin
      line_sh[i] = line_r[i + 1];
    end
    line_sh[NB-1] = in_pixel_byte;
    line_nxt = (accept && store) ? line_sh : line_r;

    col_inc  = {1'b0, col_r} + (ColsW + 1)'(1);
    band_end = (col_inc >= {1'b0, cols});
    total_x  = {1'b0, cfg.total_rows};
    page_end = ((done_r + DoneW'(BAND_ROWS)) >= total_x);
    diff     = total_x - done_r;
    if (page_end) begin
      rem = (total_x > done_r) ? FeedW'(diff) : '0;
    end else begin
      rem = FeedW'(BAND_ROWS);
    end
    feed = {rem[FeedW-1:1], 1'b0};

    cmd.has_prefix = !open_r;
    cmd.has_cr     = (done_r == '0);
    cmd.skip       = SkipW'({cfg.left_margin, 1'b0}) + SkipW'(cfg.start_offset);
    cmd.gwidth     = {cols, 3'b000};
    cmd.has_data   = last_row;
    cmd.has_feed   = last_row && band_end && (feed != '0);
    cmd.feed       = feed;

    cmd_push  = accept && needs_cmd;
    bank_load = accept && last_row;
    bank_data = line_nxt;

    row_nxt  = row_r;
    col_nxt  = col_r;
    done_nxt = done_r;
    open_nxt = open_r;
    if (accept) begin
      open_nxt = 1'b1;
      if (last_row) begin
        row_nxt = '0;
        if (band_end) begin
          col_nxt  = '0;
          open_nxt = 1'b0;
          done_nxt = page_end ? '0 : done_r + DoneW'(BAND_ROWS);
        end else begin
          col_nxt = col_inc[ColsW-1:0];
        end
      end else begin
        row_nxt = row_r + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      done_r <= '0;
      open_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      done_r <= done_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

endmodule

### hdl/rbhc_back.sv
// Back end: walks each command through its byte sequences, transposes the
// held column group and drives the result register. Depends on rbhc_pkg.
`include "assert_macros.svh"

module rbhc_back #(
  parameter int BAND_ROWS = rbhc_pkg::BandRowsDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cmd_valid,
  input  rbhc_pkg::cmd_t                         cmd,
  output logic                                   cmd_pop,
  input  logic                                   bank_load,
  input  logic [BAND_ROWS/8*8-1:0][rbhc_pkg::ByteW-1:0] bank_data,
  output logic                                   bank_busy,
  input  logic                                   pop,
  output logic                                   out_valid,
  output logic [rbhc_pkg::ByteW-1:0]             out_byte,
  output logic [rbhc_pkg::CountW-1:0]            out_repeat_count,
  output logic                                   out_last_of_run
);

  localparam int Blocks = BAND_ROWS / 8;
  localparam int NB     = Blocks * 8;
  localparam int IdxW   = $clog2(NB);
  localparam int CountW = rbhc_pkg::CountW;
  localparam int ByteW  = rbhc_pkg::ByteW;

  localparam logic [ByteW-1:0] CodeFs  = 8'd28;
  localparam logic [ByteW-1:0] CodeC   = 8'd67;
  localparam logic [ByteW-1:0] CodeB   = 8'd66;
  localparam logic [ByteW-1:0] CodeJ   = 8'd74;
  localparam logic [ByteW-1:0] CodeArg = 8'd4;
  localparam logic [ByteW-1:0] CodeCr  = 8'd13;

  typedef enum logic [2:0] {
    PH_CR,
    PH_HDR1,
    PH_ZERO,
    PH_HDR2,
    PH_DATA,
    PH_FEED
  } phase_t;

  phase_t                              phase_r, phase_nxt, nph, first_ph;
  logic [IdxW-1:0]                     idx_r, idx_nxt;
  logic                                cur_valid_r, cur_valid_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                busy_r, busy_nxt;
  logic [ByteW-1:0]                    byte_r, byte_nxt;
  logic [CountW-1:0]                   rep_r, rep_nxt;
  logic                                last_r, last_nxt;
  rbhc_pkg::cmd_t                      cur_r;
  logic [Blocks-1:0][7:0][ByteW-1:0]   bank_r, bank_rot;

  logic              out_free, beat, ph_end, nv, load, data_beat;
  logic [ByteW-1:0]  beat_byte, dbyte;
  logic [CountW-1:0] beat_rep, zrep;

  function automatic logic [ByteW-1:0] hdr_byte(logic [IdxW-1:0] i, logic [CountW-1:0] c);
    logic [ByteW-1:0] b;
    case (int'(i))
      0:       b = CodeFs;
      1:       b = CodeC;
      2:       b = CodeB;
      3, 4:    b = CodeArg;
      5:       b = c[7:0];
      default: b = ByteW'(c[CountW-1:8]);
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] feed_byte(logic [IdxW-1:0] i,
                                                 logic [rbhc_pkg::FeedW-1:0] f);
    logic [ByteW-1:0] b;
    case (int'(i))
      0:       b = CodeFs;
      1:       b = CodeC;
      2:       b = CodeJ;
      3:       b = CodeArg;
      4:       b = ByteW'(f);
      default: b = CodeCr;
    endcase
    return b;
  endfunction

  always_comb begin
    // rotate blocks; the block just sent moves to the back, one column on
    for (int b = 0; b < Blocks - 1; b++) begin
      bank_rot[b] = bank_r[b + 1];
    end
    for (int r = 0; r < 8; r++) begin
      bank_rot[Blocks-1][r] = {bank_r[0][r][ByteW-2:0], 1'b0};
      dbyte[7 - r]          = bank_r[0][r][ByteW-1];
    end

    zrep = CountW'(cur_r.skip) * CountW'(Blocks);

    if (cmd.has_prefix) begin
      first_ph = cmd.has_cr ? PH_CR : PH_HDR1;
    end else begin
      first_ph = cmd.has_data ? PH_DATA : PH_FEED;
    end

    beat_byte = '0;
    beat_rep  = CountW'(1);
    ph_end    = 1'b0;
    nph       = PH_FEED;
    nv        = 1'b0;
    unique case (phase_r)
      PH_CR: begin
        beat_byte = CodeCr;
        ph_end    = 1'b1;
        nph       = PH_HDR1;
        nv        = 1'b1;
      end
      PH_HDR1: begin
        beat_byte = hdr_byte(idx_r, CountW'(cur_r.skip));
        ph_end    = (idx_r == IdxW'(6));
        nph       = (cur_r.skip != '0) ? PH_ZERO : PH_HDR2;
        nv        = 1'b1;
      end
      PH_ZERO: begin
        beat_byte = '0;
        beat_rep  = zrep;
        ph_end    = 1'b1;
        nph       = PH_HDR2;
        nv        = 1'b1;
      end
      PH_HDR2: begin
        beat_byte = hdr_byte(idx_r, cur_r.gwidth);
        ph_end    = (idx_r == IdxW'(6));
        nph       = cur_r.has_data ? PH_DATA : PH_FEED;
        nv        = cur_r.has_data || cur_r.has_feed;
      end
      PH_DATA: begin
        beat_byte = dbyte;
        ph_end    = (idx_r == IdxW'(NB - 1));
        nph       = PH_FEED;
        nv        = cur_r.has_feed;
      end
      PH_FEED: begin
        beat_byte = feed_byte(idx_r, cur_r.feed);
        ph_end    = (idx_r == IdxW'(5));
      end
      default: begin
        ph_end = 1'b1;
      end
    endcase

    out_free  = !out_valid_r || pop;
    beat      = cur_valid_r && out_free;
    data_beat = beat && (phase_r == PH_DATA);
    load      = cmd_valid && (!cur_valid_r || (beat && ph_end && !nv));
    cmd_pop   = load;

    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    cur_valid_nxt = cur_valid_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    rep_nxt       = rep_r;
    last_nxt      = last_r;

    if (beat) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = beat_byte;
      rep_nxt       = beat_rep;
      last_nxt      = ph_end && !nv;
      if (ph_end) begin
        idx_nxt = '0;
        if (nv) begin
          phase_nxt = nph;
        end else begin
          cur_valid_nxt = 1'b0;
        end
      end else begin
        idx_nxt = idx_r + IdxW'(1);
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      cur_valid_nxt = 1'b1;
      phase_nxt     = first_ph;
      idx_nxt       = '0;
    end

    busy_nxt = busy_r;
    if (bank_load) begin
      busy_nxt = 1'b1;
    end else if (data_beat && ph_end) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CR;
      idx_r       <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
    end
    byte_r <= byte_nxt;
    rep_r  <= rep_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= cmd;
    end
    if (bank_load) begin
      bank_r <= bank_data;
    end else if (data_beat) begin
      bank_r <= bank_rot;
    end
  end

  assign bank_busy        = busy_r;
  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_repeat_count = rep_r;
  assign out_last_of_run  = last_r;

  `RBHC_NEVER(a_no_load_while_busy, bank_load && busy_r, "bank overwritten before drained")
  `RBHC_ASSERT(a_data_needs_bank, cur_valid_r && (phase_r == PH_DATA) |-> busy_r, "data phase with empty bank")
  `RBHC_ASSERT(a_idle_takes_cmd, !cur_valid_r && cmd_valid |=> cur_valid_r, "idle back end ignored queued command")

endmodule

### hdl/raster_band_to_print_head_columns.sv
// Top level of the band-to-print-head-column converter: config registers,
// front end, command queue and back end. Depends on rbhc_pkg and all rbhc_ modules.
//
// Usage:
//   Input channel: write pixel bytes with push while full is low, in band order:
//   for each column byte of a band, the BAND_ROWS row bytes top to bottom.
//   Result channel: while empty is low, out_byte/out_repeat_count/out_last_of_run
//   show the oldest result beat; pop takes it. out_last_of_run marks the final
//   beat caused by one input byte; inputs that cause nothing produce no beat.
//   Config: APB-style write of left_margin, start_offset, column_bytes and
//   total_rows at byte addresses 0, 4, 8, 12; only while the block is idle.
// Result path: an input that starts a band or closes a column group queues a
//   command; empty falls once its first beat reaches the output register.
// Throughput: one result beat per cycle from the output register while the
//   receiver pops; input bytes go in one per cycle, except that a byte that
//   needs a command waits while the command queue is full, and the last row
//   of a column group waits until the previous group's 8*(BAND_ROWS/8) data
//   beats have left the transpose bank.
// Reset: synchronous, active low; clears position counters, the command queue
//   and the output register; registers return to margin 0, offset 0, one column
//   byte, zero rows. A stalled receiver holds the current beat; the queue then
//   fills and full rises.
module raster_band_to_print_head_columns #(
  parameter int BAND_ROWS = rbhc_pkg::BandRowsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              push,
  output logic                              full,
  input  logic [rbhc_pkg::ByteW-1:0]        in_pixel_byte,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output logic [rbhc_pkg::ByteW-1:0]        out_byte,
  output logic [rbhc_pkg::CountW-1:0]       out_repeat_count,
  output logic                              out_last_of_run,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbhc_pkg::AddrW-1:0]        paddr,
  input  logic [rbhc_pkg::DataW-1:0]        pwdata,
  output logic [rbhc_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  localparam int NB = BAND_ROWS / 8 * 8;

  rbhc_pkg::cfg_t    cfg_r, cfg_nxt;
  rbhc_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  rbhc_pkg::cmd_t    fe_cmd, q_cmd;
  logic              fe_cmd_push, q_full, q_valid, q_pop;
  logic              bank_load, bank_busy, out_valid;
  logic [NB-1:0][rbhc_pkg::ByteW-1:0] bank_data;

  // register file: zero wait states, index from the word address
  assign pready  = 1'b1;
  assign reg_idx = rbhc_pkg::reg_idx_t'(paddr[rbhc_pkg::AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        rbhc_pkg::RegLeftMargin:  cfg_nxt.left_margin  = pwdata[rbhc_pkg::MarginW-1:0];
        rbhc_pkg::RegStartOffset: cfg_nxt.start_offset = pwdata[rbhc_pkg::MarginW-1:0];
        rbhc_pkg::RegColumnBytes: cfg_nxt.column_bytes = pwdata[rbhc_pkg::ColsW-1:0];
        rbhc_pkg::RegTotalRows:   cfg_nxt.total_rows   = pwdata[rbhc_pkg::RowsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rbhc_pkg::RegLeftMargin:  prdata = rbhc_pkg::DataW'(cfg_r.left_margin);
      rbhc_pkg::RegStartOffset: prdata = rbhc_pkg::DataW'(cfg_r.start_offset);
      rbhc_pkg::RegColumnBytes: prdata = rbhc_pkg::DataW'(cfg_r.column_bytes);
      rbhc_pkg::RegTotalRows:   prdata = rbhc_pkg::DataW'(cfg_r.total_rows);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_margin  <= '0;
      cfg_r.start_offset <= '0;
      cfg_r.column_bytes <= rbhc_pkg::ColsW'(1);
      cfg_r.total_rows   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: position tracking and command build
  rbhc_front #(
    .BAND_ROWS (BAND_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (push),
    .full          (full),
    .in_pixel_byte (in_pixel_byte),
    .cmd_push      (fe_cmd_push),
    .cmd           (fe_cmd),
    .cmdq_full     (q_full),
    .bank_busy     (bank_busy),
    .bank_load     (bank_load),
    .bank_data     (bank_data)
  );

  // decouple: the front keeps taking rows while the back drains beats
  rbhc_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_cmd_push),
    .din   (fe_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_cmd)
  );

  // back: sequence headers, transposed data and feeds into the result register
  rbhc_back #(
    .BAND_ROWS (BAND_ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_valid),
    .cmd              (q_cmd),
    .cmd_pop          (q_pop),
    .bank_load        (bank_load),
    .bank_data        (bank_data),
    .bank_busy        (bank_busy),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_last_of_run  (out_last_of_run)
  );

  assign empty = !out_valid;

endmodule
